// ===== hdl/tvs_pkg.sv =====
package tvs_pkg;

    localparam int STACK_ENTRIES_DEF = 64;
    localparam int SPARE_ENTRIES_DEF = 5;
    localparam int FRAME_WINDOW_DEF  = 20;

    // cells per registered link of the read collection chain
    localparam int CELLS_PER_HOP = 8;

    localparam int KIND_W  = 2;
    localparam int TAG_W   = 3;
    localparam int VALUE_W = 64;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 6;
    localparam int FAULT_W = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET_TOP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

    localparam logic [TAG_W-1:0] TAG_NIL   = 3'd0;
    localparam logic [TAG_W-1:0] TAG_INT   = 3'd2;
    localparam logic [TAG_W-1:0] TAG_FLT   = 3'd3;
    localparam logic [TAG_W-1:0] TAG_LAST  = 3'd5;

    localparam logic [FAULT_W-1:0] FLT_OK       = 2'd0;
    localparam logic [FAULT_W-1:0] FLT_OVERFLOW = 2'd1;
    localparam logic [FAULT_W-1:0] FLT_BOUNDS   = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic   wr_en;
        logic   fill_en;
        entry_t wr_data;
    } cell_cmd_t;

endpackage

// ===== hdl/tvs_cell.sv =====
module tvs_cell #(
    parameter int AW       = 6,
    parameter int MY_POS   = 0,
    parameter bit LINK_REG = 1'b0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tvs_pkg::cell_cmd_t cmd,
    input  logic [AW-1:0]      wr_pos,
    input  logic [AW-1:0]      fill_lo,
    input  logic [AW-1:0]      fill_hi,
    input  logic [AW-1:0]      rd_pos,
    input  tvs_pkg::entry_t    bus_in,
    output tvs_pkg::entry_t    bus_out
);
    import tvs_pkg::*;

    localparam logic [AW-1:0] POS = AW'(MY_POS);

    entry_t entry_reg;
    entry_t entry_next;
    entry_t hit_data;
    entry_t bus_next;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (cmd.wr_en && (wr_pos == POS))
        begin
            entry_next = cmd.wr_data;
        end
        else if (cmd.fill_en && (POS >= fill_lo) && (POS <= fill_hi))
        begin
            entry_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    // read word rides the chain; only the addressed cell adds its entry
    assign hit_data = (rd_pos == POS) ? entry_reg : '0;
    assign bus_next = entry_t'(bus_in | hit_data);

    generate
        if (LINK_REG)
        begin : g_link
            entry_t bus_reg;
            always_ff @(posedge clk)
            begin
                bus_reg <= bus_next;
            end
            assign bus_out = bus_reg;
        end
        else
        begin : g_pass
            assign bus_out = bus_next;
        end
    endgenerate

    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_en && cmd.fill_en))
        else $error("cell got write and fill together");

endmodule

// ===== hdl/tagged_value_operand_stack_unit.sv =====
// Operand stack of tagged 64-bit values held in a row of cells. A word is taken
// when start is high and busy is low; its result appears for one cycle with done
// and cannot be held off. Push, set-top (growing fills nil into every new entry
// at once), no-op and refused read words give their result in the next cycle,
// with busy staying low. A read raises busy while the addressed entry travels
// along the cell chain, crossing eight cells per cycle, and its result follows
// as busy falls. Reset loads every entry with nil at once.
module tagged_value_operand_stack_unit #(
    parameter int STACK_ENTRIES = tvs_pkg::STACK_ENTRIES_DEF,
    parameter int SPARE_ENTRIES = tvs_pkg::SPARE_ENTRIES_DEF,
    parameter int FRAME_WINDOW  = tvs_pkg::FRAME_WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tvs_pkg::KIND_W-1:0]    kind,
    input  logic [tvs_pkg::TAG_W-1:0]     push_tag,
    input  logic [tvs_pkg::VALUE_W-1:0]   push_value,
    input  logic signed [tvs_pkg::INDEX_W-1:0] index,
    output logic                          done,
    output logic [tvs_pkg::TAG_W-1:0]     read_tag,
    output logic [tvs_pkg::VALUE_W-1:0]   read_value,
    output logic                          is_integer,
    output logic                          is_float,
    output logic                          truth,
    output logic                          is_nil,
    output logic [tvs_pkg::COUNT_W-1:0]   count_above_base,
    output logic [tvs_pkg::FAULT_W-1:0]   fault
);
    import tvs_pkg::*;

    localparam int LIMIT = STACK_ENTRIES - SPARE_ENTRIES;
    localparam int AW    = $clog2(STACK_ENTRIES);
    localparam int TW    = $clog2(STACK_ENTRIES + 1);
    localparam int CW    = TW + 9;
    localparam int HOPS  = (STACK_ENTRIES + CELLS_PER_HOP - 1) / CELLS_PER_HOP;
    localparam int HW    = $clog2(HOPS + 1);

    localparam logic signed [CW-1:0] LIMIT_S = CW'(LIMIT);
    localparam logic signed [CW-1:0] N_S     = CW'(STACK_ENTRIES);
    localparam logic signed [CW-1:0] FW_S    = CW'(FRAME_WINDOW);
    localparam logic signed [CW-1:0] ONE_S   = CW'(1);

    localparam logic ST_IDLE    = 1'b0;
    localparam logic ST_COLLECT = 1'b1;

    logic              state_reg, state_next;
    logic [TW-1:0]     top_reg, top_next;
    logic [HW-1:0]     hop_cnt_reg, hop_cnt_next;
    logic [AW-1:0]     rd_pos_reg, rd_pos_next;
    logic              done_reg, done_next;
    logic [TAG_W-1:0]  read_tag_reg, read_tag_next;
    logic [VALUE_W-1:0] read_value_reg, read_value_next;
    logic              is_integer_reg, is_integer_next;
    logic              is_float_reg, is_float_next;
    logic              truth_reg, truth_next;
    logic              is_nil_reg, is_nil_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [FAULT_W-1:0] fault_reg, fault_next;

    logic              accept;
    logic signed [CW-1:0] idx_s;
    logic signed [CW-1:0] top_s;
    logic signed [CW-1:0] sum_s;
    logic [CW-1:0]     cnt_w;
    logic [TAG_W-1:0]  wr_tag;
    cell_cmd_t         cmd;
    logic [AW-1:0]     wr_pos;
    logic [AW-1:0]     fill_lo;
    logic [AW-1:0]     fill_hi;
    entry_t            bus_link [0:STACK_ENTRIES];
    entry_t            rd_word;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign idx_s  = {{(CW-INDEX_W){index[INDEX_W-1]}}, index};
    assign top_s  = CW'(top_reg);
    assign sum_s  = top_s + idx_s;
    assign wr_tag = (push_tag > TAG_LAST) ? TAG_NIL : push_tag;

    assign wr_pos  = top_reg[AW-1:0];
    assign fill_lo = top_reg[AW-1:0];
    assign fill_hi = idx_s[AW-1:0];
    assign rd_word = bus_link[STACK_ENTRIES];
    assign cnt_w   = CW'(top_next) - CW'(1);

    always_comb
    begin
        state_next      = state_reg;
        top_next        = top_reg;
        hop_cnt_next    = hop_cnt_reg;
        rd_pos_next     = rd_pos_reg;
        done_next       = 1'b0;
        read_tag_next   = TAG_NIL;
        read_value_next = '0;
        is_integer_next = 1'b0;
        is_float_next   = 1'b0;
        truth_next      = 1'b0;
        is_nil_next     = 1'b0;
        fault_next      = FLT_OK;
        cmd             = '0;
        cmd.wr_data.tag   = wr_tag;
        cmd.wr_data.value = (wr_tag == TAG_NIL) ? '0 : push_value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    unique case (kind)
                        KIND_PUSH:
                        begin
                            if ((top_s + ONE_S > LIMIT_S) || (top_s >= N_S))
                            begin
                                fault_next = FLT_OVERFLOW;
                            end
                            else
                            begin
                                cmd.wr_en = 1'b1;
                                top_next  = top_reg + 1'b1;
                            end
                        end
                        KIND_SET_TOP:
                        begin
                            if (!idx_s[CW-1])
                            begin
                                if (idx_s > LIMIT_S - ONE_S)
                                begin
                                    fault_next = FLT_OVERFLOW;
                                end
                                else
                                begin
                                    // clear entries top .. index when growing
                                    cmd.fill_en = (top_s <= idx_s);
                                    top_next    = TW'(idx_s + ONE_S);
                                end
                            end
                            else if (sum_s < ONE_S)
                            begin
                                fault_next = FLT_BOUNDS;
                            end
                            else
                            begin
                                top_next = TW'(sum_s);
                            end
                        end
                        KIND_READ:
                        begin
                            if (!idx_s[CW-1])
                            begin
                                if ((idx_s >= FW_S) || (idx_s >= N_S))
                                begin
                                    fault_next = FLT_BOUNDS;
                                end
                                else
                                begin
                                    rd_pos_next  = idx_s[AW-1:0];
                                    state_next   = ST_COLLECT;
                                    hop_cnt_next = HW'(HOPS);
                                    done_next    = 1'b0;
                                end
                            end
                            else if (sum_s < ONE_S)
                            begin
                                fault_next = FLT_BOUNDS;
                            end
                            else
                            begin
                                rd_pos_next  = sum_s[AW-1:0];
                                state_next   = ST_COLLECT;
                                hop_cnt_next = HW'(HOPS);
                                done_next    = 1'b0;
                            end
                        end
                        KIND_NONE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_COLLECT:
            begin
                if (hop_cnt_reg == '0)
                begin
                    state_next      = ST_IDLE;
                    done_next       = 1'b1;
                    read_tag_next   = rd_word.tag;
                    read_value_next = rd_word.value;
                    is_integer_next = (rd_word.tag == TAG_INT);
                    is_float_next   = (rd_word.tag == TAG_FLT);
                    is_nil_next     = (rd_word.tag == TAG_NIL);
                    truth_next      = (rd_word.tag != TAG_NIL) && (|rd_word.value[7:0]);
                end
                else
                begin
                    hop_cnt_next = hop_cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        count_next = cnt_w[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            top_reg     <= TW'(1);
            hop_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            top_reg     <= top_next;
            hop_cnt_reg <= hop_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pos_reg     <= rd_pos_next;
        read_tag_reg   <= read_tag_next;
        read_value_reg <= read_value_next;
        is_integer_reg <= is_integer_next;
        is_float_reg   <= is_float_next;
        truth_reg      <= truth_next;
        is_nil_reg     <= is_nil_next;
        count_reg      <= count_next;
        fault_reg      <= fault_next;
    end

    assign bus_link[0] = '0;

    generate
        for (genvar i = 0; i < STACK_ENTRIES; i++)
        begin : g_cell
            tvs_cell #(
                .AW       (AW),
                .MY_POS   (i),
                .LINK_REG (((i % CELLS_PER_HOP) == (CELLS_PER_HOP - 1)) ||
                           (i == STACK_ENTRIES - 1))
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd),
                .wr_pos  (wr_pos),
                .fill_lo (fill_lo),
                .fill_hi (fill_hi),
                .rd_pos  (rd_pos_reg),
                .bus_in  (bus_link[i]),
                .bus_out (bus_link[i+1])
            );
        end
    endgenerate

    assign done             = done_reg;
    assign read_tag         = read_tag_reg;
    assign read_value       = read_value_reg;
    assign is_integer       = is_integer_reg;
    assign is_float         = is_float_reg;
    assign truth            = truth_reg;
    assign is_nil           = is_nil_reg;
    assign count_above_base = count_reg;
    assign fault            = fault_reg;

    a_no_done_collect: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COLLECT) |-> !done_reg)
        else $error("result word while read still collecting");

    a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
        (top_s >= ONE_S) && (top_s <= N_S))
        else $error("top pointer out of range");

    a_top_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(top_reg))
        else $error("top pointer moved without a word");

    a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (fault_reg != FLT_OK)) |->
        ((read_tag_reg == TAG_NIL) && (read_value_reg == '0) && !truth_reg))
        else $error("refused word carries read data");

endmodule
